@@ rtl/core/priority_queue_with_quantum_requeue_assert.svh @@
// Assertion macros for the queue checker.
`ifndef PRIORITY_QUEUE_WITH_QUANTUM_REQUEUE_ASSERT_SVH
`define PRIORITY_QUEUE_WITH_QUANTUM_REQUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PQQR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define PQQR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pqqr_pkg.sv @@
// Shared types and constants of the quantum requeue priority queue.
package pqqr_pkg;

  localparam int QueueDepth = 64;
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int UrgW       = 8;
  localparam int WorkW      = 16;
  localparam int TagW       = 24;
  localparam int QuantW     = 4;
  localparam logic [QuantW-1:0] QuantReset = 4'd3;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_SERVE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE    = 1'b0,
    BK_REQUEUE = 1'b1
  } back_state_t;

  typedef struct packed {
    logic [UrgW-1:0]  urg;
    logic [WorkW-1:0] cnt;
    logic [TagW-1:0]  tag;
    logic             first;
  } job_t;

  typedef struct packed {
    cmd_t cmd;
    job_t job;
  } cmd_item_t;

  typedef struct packed {
    status_t          status;
    job_t             job;
    logic             requeued;
    logic [WorkW-1:0] remaining;
  } result_t;

endpackage

@@ rtl/core/priority_queue_with_quantum_requeue.sv @@
// Top level of the priority queue with quantum requeue.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   tuser: cmd; tdata: urgency, work_count, tag, first
//  m_*      out  m_tvalid/m_tready   tuser: status; tdata: served job, requeued, remaining
//  cfg_*    in   cfg_we              cfg_wdata: service_quantum
//
// Insert and empty/full serves finish in BK_IDLE in the back end; a serve that
// requeues also passes BK_REQUEUE (pop, then reinsert into the sorted row).
// Beats land in a 2-entry front queue, so the slave side keeps taking beats
// while a result waits on the master side. rst is synchronous: queue empty,
// quantum 3. A stalled master side stops the back end, then the front queue once full.
module priority_queue_with_quantum_requeue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // urgency, work_count, client_tag, first_visit, zero pad
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // served_urgency, served_count, served_tag,
                                 // served_first, requeued, remaining_count, zero pad
  output logic [1:0]  m_tuser,   // status
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata  // service_quantum
);
  import pqqr_pkg::*;

  logic [QuantW-1:0] quantum;
  cmd_item_t         s_item;
  cmd_item_t         q_item;
  logic              q_valid;
  logic              q_pop;
  result_t           res;

  // Quantum register; the user must write it only while idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QuantReset;
    end else if (cfg_we) begin
      quantum <= cfg_wdata;
    end
  end

  // Unpack the slave beat.
  always_comb begin
    s_item.cmd       = cmd_t'(s_tuser);
    s_item.job.urg   = s_tdata[7:0];
    s_item.job.cnt   = s_tdata[23:8];
    s_item.job.tag   = s_tdata[47:24];
    s_item.job.first = s_tdata[48];
  end

  pqqr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (s_item),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_item  (q_item)
  );

  pqqr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .quantum   (quantum),
    .in_valid  (q_valid),
    .in_pop    (q_pop),
    .in_item   (q_item),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  // Pack the result beat, first field lowest.
  assign m_tuser = res.status;
  assign m_tdata = {6'b0, res.remaining, res.requeued, res.job.first,
                    res.job.tag, res.job.cnt, res.job.urg};

endmodule

@@ rtl/core/pqqr_front.sv @@
// Front end: takes command beats into a two-entry queue for the back end.
module pqqr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pqqr_pkg::cmd_item_t in_item,
  output logic                out_valid,
  input  logic                out_pop,
  output pqqr_pkg::cmd_item_t out_item
);
  import pqqr_pkg::*;

  cmd_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_item;
  end

endmodule

@@ rtl/core/pqqr_engine.sv @@
// Back end: sorted shift row of jobs, serve/requeue sequencer, result register.
module pqqr_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [pqqr_pkg::QuantW-1:0]   quantum,
  input  logic                          in_valid,
  output logic                          in_pop,
  input  pqqr_pkg::cmd_item_t           in_item,
  output logic                          res_valid,
  input  logic                          res_ready,
  output pqqr_pkg::result_t             res
);
  import pqqr_pkg::*;

  back_state_t          state;
  back_state_t          state_next;
  job_t                 row [QueueDepth];
  logic [QueueDepth-1:0] le;
  logic [CntW-1:0]      count;
  logic [CntW-1:0]      count_next;
  job_t                 held;
  job_t                 held_next;
  job_t                 ins_job;
  logic                 ins_en;
  logic                 pop_en;
  logic                 take;
  logic                 full;
  logic                 want_requeue;
  result_t              res_next;

  assign full = (count == CntW'(QueueDepth));
  assign take = (state == BK_IDLE) && in_valid && (!res_valid || res_ready);
  assign in_pop = take;
  assign want_requeue = (row[0].cnt > {{(WorkW-QuantW){1'b0}}, quantum});

  // Cell i holds a job at or before the new one when its urgency is not larger.
  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      le[i] = (CntW'(i) < count) && (row[i].urg <= ins_job.urg);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (take && in_item.cmd == CMD_SERVE && count != '0 && want_requeue) begin
          state_next = BK_REQUEUE;
        end
      end
      BK_REQUEUE: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    ins_en     = 1'b0;
    pop_en     = 1'b0;
    ins_job    = in_item.job;
    count_next = count;
    held_next  = held;
    res_next   = '0;
    unique case (state)
      BK_IDLE: begin
        if (take) begin
          if (in_item.cmd == CMD_INSERT) begin
            if (full) begin
              res_next.status = ST_FULL;
            end else begin
              res_next.status = ST_INSERTED;
              ins_en          = 1'b1;
              count_next      = count + 1'b1;
            end
          end else if (count == '0) begin
            res_next.status = ST_EMPTY;
          end else begin
            res_next.status = ST_SERVED;
            res_next.job    = row[0];
            pop_en          = 1'b1;
            count_next      = count - 1'b1;
            if (want_requeue) begin
              res_next.requeued  = 1'b1;
              res_next.remaining = row[0].cnt - {{(WorkW-QuantW){1'b0}}, quantum};
              held_next          = row[0];
              held_next.cnt      = res_next.remaining;
              held_next.first    = 1'b0;
            end
          end
        end
      end
      BK_REQUEUE: begin
        ins_job    = held;
        ins_en     = 1'b1;
        count_next = count + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (take) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res  <= res_next;
      held <= held_next;
    end
  end

  // Each cell keeps, takes the new job, or takes its left neighbor (insert);
  // or takes its right neighbor (pop).
  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (ins_en) begin
        if (!le[g]) begin
          if (g == 0) begin
            row[g] <= ins_job;
          end else if (le[(g == 0) ? 0 : g-1]) begin
            row[g] <= ins_job;
          end else begin
            row[g] <= row[(g == 0) ? 0 : g-1];
          end
        end
      end else if (pop_en) begin
        if (g < QueueDepth-1) begin
          row[g] <= row[(g < QueueDepth-1) ? g+1 : g];
        end
      end
    end
  end

endmodule

@@ rtl/core/pqqr_checker.sv @@
// Port-level checker for the queue, bound to the top level.
`include "priority_queue_with_quantum_requeue_assert.svh"

module pqqr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import pqqr_pkg::*;

  `PQQR_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result beat dropped")
  `PQQR_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `PQQR_ASSERT_NOW(a_nonserve_zero, m_tvalid && m_tuser != ST_SERVED, m_tdata == '0, "non-serve result carries data")
  `PQQR_ASSERT_NOW(a_finish_zero, m_tvalid && m_tuser == ST_SERVED && !m_tdata[49], m_tdata[65:50] == '0, "finished job shows work left")

endmodule

bind priority_queue_with_quantum_requeue pqqr_checker u_pqqr_checker (.*);
